// File: rtl/adpcm_2bit_decoder_assert.svh
// Assertion macros for the decoder RTL.
`ifndef ADPCM_2BIT_DECODER_ASSERT_SVH
`define ADPCM_2BIT_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define A2D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define A2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/a2d_pkg.sv
package a2d_pkg;

  localparam int TrackW      = 24;
  localparam int UpW         = 5;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 24;
  localparam int MaxUpsample = 16;
  localparam int QueueDepth  = 2;

  localparam logic [CfgIdxW-1:0] REG_TRACK_LENGTH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_UPSAMPLE     = 2'd1;

  localparam logic [4:0] StepStart = 5'd10;
  localparam logic [4:0] StepLast  = 5'd24;

  localparam logic signed [9:0] PredMin = -10'sd128;
  localparam logic signed [9:0] PredMax = 10'sd127;

  localparam logic [UpW-1:0] UpsampleReset = 5'd1;

  typedef struct packed {
    logic       restart;
    logic [7:0] packed_byte;
  } item_t;

  // queue head as seen by the decode engine
  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  function automatic logic [6:0] step_size(input logic [4:0] pos);
    logic [6:0] s;
    unique case (pos)
      5'd0:  s = 7'd2;
      5'd1:  s = 7'd3;
      5'd2:  s = 7'd4;
      5'd3:  s = 7'd5;
      5'd4:  s = 7'd6;
      5'd5:  s = 7'd7;
      5'd6:  s = 7'd8;
      5'd7:  s = 7'd10;
      5'd8:  s = 7'd12;
      5'd9:  s = 7'd14;
      5'd10: s = 7'd16;
      5'd11: s = 7'd19;
      5'd12: s = 7'd22;
      5'd13: s = 7'd26;
      5'd14: s = 7'd31;
      5'd15: s = 7'd36;
      5'd16: s = 7'd42;
      5'd17: s = 7'd49;
      5'd18: s = 7'd57;
      5'd19: s = 7'd66;
      5'd20: s = 7'd77;
      5'd21: s = 7'd89;
      5'd22: s = 7'd103;
      5'd23: s = 7'd119;
      default: s = 7'd127;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/adpcm_2bit_decoder.sv
// 2-bit ADPCM decoder, 8-bit signed PCM out.
// Input stream: in_tdata = packed byte of four 2-bit codes (first in bits 1:0),
// in_tuser = restart (reset predictor, step position and sample count first).
// Output stream: out_tdata = sample, out_tlast = last result of the byte,
// out_tuser = track done (sample count reached zero with this sample).
// Config: cfg_we/cfg_index/cfg_wdata; index 0 = track length, 1 = upsample
// factor. Write only while the block is idle.
// Bytes go into a two-entry queue; the decode engine pulls one byte at a time.
// Per byte the engine pops it, then for each of n codes (n up to 4, fewer at
// the track end) runs one predictor step and R output transactions, where R =
// repeat count. It takes the next byte only after the last of these.
// On an empty block a byte passes through the queue, the idle state and the
// decode state before its first result is valid.
// A byte arriving with the track used up produces no output.
// Reset (rst_n low, synchronous) clears the queue, predictor to 0, step
// position to 10, sample count to 0, track length 0, upsample factor 1.
// When out_tready is low the current sample holds and the engine stalls; the
// queue keeps taking bytes until it is full, then in_tready drops.
module adpcm_2bit_decoder #(
  parameter int MAX_UPSAMPLE = a2d_pkg::MaxUpsample
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] packed_byte
  input  logic                          in_tuser,   // [0] restart
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic signed [7:0]             out_tdata,  // [7:0] sample
  output logic                          out_tlast,
  output logic                          out_tuser,  // [0] track_done
  input  logic                          cfg_we,
  input  logic [a2d_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [a2d_pkg::CfgDataW-1:0]  cfg_wdata
);

  a2d_pkg::item_t   in_item;
  a2d_pkg::q_head_t head;
  logic             pop;

  assign in_item.packed_byte = in_tdata;
  assign in_item.restart     = in_tuser;

  a2d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_item   (in_item),
    .head      (head),
    .pop       (pop)
  );

  a2d_core #(
    .MAX_UPSAMPLE (MAX_UPSAMPLE)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_sample (out_tdata),
    .out_last   (out_tlast),
    .out_done   (out_tuser)
  );

endmodule

// File: rtl/a2d_queue.sv
module a2d_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  a2d_pkg::item_t  in_item,
  output a2d_pkg::q_head_t head,
  input  logic            pop
);

  localparam int PtrW = (a2d_pkg::QueueDepth > 1) ? $clog2(a2d_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(a2d_pkg::QueueDepth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(a2d_pkg::QueueDepth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(a2d_pkg::QueueDepth);

  a2d_pkg::item_t    slots_r [a2d_pkg::QueueDepth];
  logic [PtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]   count_r, count_nxt;
  logic              push, do_pop;

  assign in_tready  = (count_r != CntFull);
  assign push       = in_tvalid && in_tready;
  assign do_pop     = pop && (count_r != '0);
  assign head.valid = (count_r != '0);
  assign head.item  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// File: rtl/a2d_core.sv
`include "adpcm_2bit_decoder_assert.svh"

module a2d_core #(
  parameter int MAX_UPSAMPLE = a2d_pkg::MaxUpsample
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [a2d_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [a2d_pkg::CfgDataW-1:0]   cfg_wdata,
  input  a2d_pkg::q_head_t               head,
  output logic                           pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic signed [7:0]              out_sample,
  output logic                           out_last,
  output logic                           out_done
);

  localparam int RepW = $clog2(MAX_UPSAMPLE + 1);
  localparam logic [a2d_pkg::UpW-1:0] MaxUp = a2d_pkg::UpW'(MAX_UPSAMPLE);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DECODE = 3'b010,
    ST_EMIT   = 3'b100
  } state_t;

  state_t                        state_r, state_nxt;
  logic [a2d_pkg::TrackW-1:0]    track_len_r;
  logic [a2d_pkg::UpW-1:0]       upsample_r;
  logic signed [7:0]             pred_r, pred_nxt;
  logic [4:0]                    pos_r, pos_nxt;
  logic [a2d_pkg::TrackW-1:0]    left_r, left_nxt;
  logic [7:0]                    byte_r, byte_nxt;
  logic [1:0]                    idx_r, idx_nxt;
  logic [RepW-1:0]               rep_r, rep_nxt;
  logic signed [7:0]             sample_r, sample_nxt;
  logic                          final_r, final_nxt;
  logic                          done_r, done_nxt;

  logic [a2d_pkg::UpW-1:0]       reps_eff;
  logic                          rep_last;
  logic [7:0]                    codes;
  logic [1:0]                    code;
  logic [6:0]                    step;
  logic [7:0]                    delta;
  logic signed [9:0]             pred_ext, delta_ext, sum;
  logic signed [7:0]             clamped;
  logic [5:0]                    pos_up;
  logic [4:0]                    pos_adj;
  logic [a2d_pkg::TrackW-1:0]    left_eff;

  // effective repeat count: zero acts as one, saturate at the maximum
  always_comb begin
    if (upsample_r == '0) begin
      reps_eff = a2d_pkg::UpW'(1);
    end else if (upsample_r > MaxUp) begin
      reps_eff = MaxUp;
    end else begin
      reps_eff = upsample_r;
    end
  end

  assign rep_last = (a2d_pkg::UpW'(rep_r) == reps_eff - a2d_pkg::UpW'(1));

  // one code through the predictor
  always_comb begin
    codes     = byte_r >> {idx_r, 1'b0};
    code      = codes[1:0];
    step      = a2d_pkg::step_size(pos_r);
    delta     = {2'b00, step[6:1]} + (code[0] ? {1'b0, step} : 8'd0);
    pred_ext  = 10'(pred_r);
    delta_ext = $signed({2'b00, delta});
    sum       = code[1] ? (pred_ext - delta_ext) : (pred_ext + delta_ext);
    if (sum < a2d_pkg::PredMin) begin
      clamped = a2d_pkg::PredMin[7:0];
    end else if (sum > a2d_pkg::PredMax) begin
      clamped = a2d_pkg::PredMax[7:0];
    end else begin
      clamped = sum[7:0];
    end
    pos_up = {1'b0, pos_r} + 6'd2;
    if (code[0]) begin
      pos_adj = (pos_up > {1'b0, a2d_pkg::StepLast}) ? a2d_pkg::StepLast : pos_up[4:0];
    end else begin
      pos_adj = (pos_r == '0) ? 5'd0 : pos_r - 5'd1;
    end
  end

  assign left_eff = head.item.restart ? track_len_r : left_r;

  always_comb begin
    state_nxt  = state_r;
    pred_nxt   = pred_r;
    pos_nxt    = pos_r;
    left_nxt   = left_r;
    byte_nxt   = byte_r;
    idx_nxt    = idx_r;
    rep_nxt    = rep_r;
    sample_nxt = sample_r;
    final_nxt  = final_r;
    done_nxt   = done_r;
    pop        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          if (head.item.restart) begin
            pred_nxt = '0;
            pos_nxt  = a2d_pkg::StepStart;
            left_nxt = track_len_r;
          end
          byte_nxt = head.item.packed_byte;
          idx_nxt  = '0;
          // a used-up track swallows the byte with no results
          if (left_eff != '0) begin
            state_nxt = ST_DECODE;
          end
        end
      end
      ST_DECODE: begin
        pred_nxt   = clamped;
        pos_nxt    = pos_adj;
        left_nxt   = left_r - 1'b1;
        sample_nxt = clamped;
        done_nxt   = (left_r == a2d_pkg::TrackW'(1));
        final_nxt  = (idx_r == 2'd3) || (left_r == a2d_pkg::TrackW'(1));
        rep_nxt    = '0;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_tready) begin
          if (rep_last) begin
            if (final_r) begin
              state_nxt = ST_IDLE;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = ST_DECODE;
            end
          end else begin
            rep_nxt = rep_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      track_len_r <= '0;
      upsample_r  <= a2d_pkg::UpsampleReset;
      pred_r      <= '0;
      pos_r       <= a2d_pkg::StepStart;
      left_r      <= '0;
    end else begin
      state_r <= state_nxt;
      pred_r  <= pred_nxt;
      pos_r   <= pos_nxt;
      left_r  <= left_nxt;
      if (cfg_we && (cfg_index == a2d_pkg::REG_TRACK_LENGTH)) begin
        track_len_r <= cfg_wdata[a2d_pkg::TrackW-1:0];
      end else if (cfg_we && (cfg_index == a2d_pkg::REG_UPSAMPLE)) begin
        upsample_r <= cfg_wdata[a2d_pkg::UpW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r   <= byte_nxt;
    idx_r    <= idx_nxt;
    rep_r    <= rep_nxt;
    sample_r <= sample_nxt;
    final_r  <= final_nxt;
    done_r   <= done_nxt;
  end

  assign out_tvalid = (state_r == ST_EMIT);
  assign out_sample = sample_r;
  assign out_last   = final_r && rep_last;
  assign out_done   = done_r;

  `A2D_ASSERT_NOW(a_pos_range, 1'b1, pos_r <= a2d_pkg::StepLast, "step position out of range")
  `A2D_ASSERT_NEXT(a_left_dec, state_r == ST_DECODE, left_r == $past(left_r) - 1'b1, "count not decremented")
  `A2D_ASSERT_NEXT(a_last_idle, out_tvalid && out_tready && out_last, state_r == ST_IDLE, "no idle after last")
  `A2D_ASSERT_NEXT(a_next_code, state_r == ST_EMIT && out_tready && rep_last && !final_r, state_r == ST_DECODE && idx_r == $past(idx_r) + 2'd1, "code index not advanced")

endmodule

// File: test/adpcm_2bit_decoder_checker.sv
`timescale 1ns / 1ps

module adpcm_2bit_decoder_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] packed_byte
  input  logic                          in_tuser,   // [0] restart
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic signed [7:0]             out_tdata,  // [7:0] sample
  input  logic                          out_tlast,
  input  logic                          out_tuser,  // [0] track_done
  input  logic                          cfg_we,
  input  logic [a2d_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [a2d_pkg::CfgDataW-1:0]  cfg_wdata,
  output int                            errors,
  output int                            pending,
  output int                            decoded_bytes
);

  typedef struct packed {
    logic [7:0] sample;
    logic       last;
    logic       done;
  } pcm_result_t;

  // entry 0 sits in the lowest bits
  localparam logic [24:0][6:0] STEP_TBL = {
    7'd127, 7'd119, 7'd103, 7'd89, 7'd77, 7'd66, 7'd57, 7'd49, 7'd42, 7'd36,
    7'd31, 7'd26, 7'd22, 7'd19, 7'd16, 7'd14, 7'd12, 7'd10, 7'd8, 7'd7,
    7'd6, 7'd5, 7'd4, 7'd3, 7'd2
  };

  logic signed [7:0]          pcm_level;
  logic [4:0]                 step_idx;
  logic [a2d_pkg::TrackW-1:0] codes_left;
  logic [a2d_pkg::TrackW-1:0] track_len;
  logic [a2d_pkg::UpW-1:0]    repeat_cfg;
  pcm_result_t                pcm_expected[$];

  // Decodes one byte into the expected samples; returns the number of codes used.
  function automatic int decode_byte(input logic [7:0] codes, input logic restart);
    int          reps;
    int          n;
    int          total;
    int          k;
    int          level;
    int          delta;
    int          idx;
    logic [6:0]  step;
    logic [1:0]  code;
    logic        done;
    pcm_result_t res;
    if (restart) begin
      pcm_level  = '0;
      step_idx   = a2d_pkg::StepStart;
      codes_left = track_len;
    end
    if (repeat_cfg == 0) reps = 1;
    else if (repeat_cfg > a2d_pkg::MaxUpsample) reps = a2d_pkg::MaxUpsample;
    else reps = int'(repeat_cfg);
    n = (codes_left < 4) ? int'(codes_left) : 4;
    total = n * reps;
    k = 0;
    for (int i = 0; i < n; i++) begin
      code  = codes[2*i +: 2];
      step  = STEP_TBL[step_idx];
      delta = int'(step) >>> 1;
      if (code[0]) delta += int'(step);
      level = code[1] ? int'(pcm_level) - delta : int'(pcm_level) + delta;
      if (level < -128) level = -128;
      if (level > 127) level = 127;
      pcm_level = level[7:0];
      idx = int'(step_idx);
      if (code[0]) idx += 2;
      else idx -= 1;
      if (idx < 0) idx = 0;
      if (idx > int'(a2d_pkg::StepLast)) idx = int'(a2d_pkg::StepLast);
      step_idx   = idx[4:0];
      codes_left = codes_left - 1'b1;
      done       = (codes_left == 0);
      for (int r = 0; r < reps; r++) begin
        res.sample = pcm_level;
        res.last   = (k == total - 1);
        res.done   = done;
        pcm_expected.push_back(res);
        k++;
      end
    end
    return n;
  endfunction

  always @(posedge clk) begin : monitor
    pcm_result_t want;
    if (!rst_n) begin
      pcm_level  = '0;
      step_idx   = a2d_pkg::StepStart;
      codes_left = '0;
      track_len  = '0;
      repeat_cfg = a2d_pkg::UpsampleReset;
      pcm_expected.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == a2d_pkg::REG_TRACK_LENGTH) begin
          track_len = cfg_wdata[a2d_pkg::TrackW-1:0];
        end else if (cfg_index == a2d_pkg::REG_UPSAMPLE) begin
          repeat_cfg = cfg_wdata[a2d_pkg::UpW-1:0];
        end
      end
      if (out_tvalid && out_tready) begin
        if (pcm_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction, expected none, got sample %0d last %0b done %0b",
                   $time, out_tdata, out_tlast, out_tuser);
        end else begin
          want = pcm_expected.pop_front();
          if (out_tdata !== want.sample) begin
            errors++;
            $display("%0t: sample mismatch, expected %0d, got %0d",
                     $time, $signed(want.sample), out_tdata);
          end
          if (out_tlast !== want.last) begin
            errors++;
            $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, out_tlast);
          end
          if (out_tuser !== want.done) begin
            errors++;
            $display("%0t: track_done mismatch, expected %0b, got %0b",
                     $time, want.done, out_tuser);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (decode_byte(in_tdata, in_tuser) > 0) decoded_bytes <= decoded_bytes + 1;
      end
    end
    pending <= pcm_expected.size();
  end

endmodule

// File: test/adpcm_2bit_decoder_tb.sv
`timescale 1ns / 1ps

module adpcm_2bit_decoder_tb;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 12;

  // indexes with no register behind them
  localparam logic [a2d_pkg::CfgIdxW-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [a2d_pkg::CfgIdxW-1:0] REG_SPARE_3 = 2'd3;
  localparam logic [a2d_pkg::TrackW-1:0]  TRACK_MAX   = '1;

  logic                         clk        = 1'b0;
  logic                         rst_n      = 1'b0;
  logic                         in_tvalid  = 1'b0;
  logic                         in_tready;
  logic [7:0]                   in_tdata   = '0;
  logic                         in_tuser   = 1'b0;
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic signed [7:0]            out_tdata;
  logic                         out_tlast;
  logic                         out_tuser;
  logic                         cfg_we     = 1'b0;
  logic [a2d_pkg::CfgIdxW-1:0]  cfg_index  = '0;
  logic [a2d_pkg::CfgDataW-1:0] cfg_wdata  = '0;
  int                           errors;
  int                           pending;
  int                           decoded_bytes;
  bit                           steady_in;

  adpcm_2bit_decoder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  adpcm_2bit_decoder_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .errors        (errors),
    .pending       (pending),
    .decoded_bytes (decoded_bytes)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  // sink side: ready bursts broken by short and occasional long stalls
  initial begin : sink
    int burst;
    int stall;
    int pick;
    forever begin
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      out_tready <= 1'b1;
      repeat (burst) @(posedge clk);
      pick = $urandom_range(0, 99);
      if (pick < 20) stall = 0;
      else if (pick < 85) stall = $urandom_range(1, 3);
      else stall = $urandom_range(8, 40);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic write_reg(input logic [a2d_pkg::CfgIdxW-1:0] idx,
                           input logic [a2d_pkg::CfgDataW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [a2d_pkg::CfgDataW-1:0] len,
                           input logic [a2d_pkg::CfgDataW-1:0] up);
    write_reg(a2d_pkg::REG_TRACK_LENGTH, len);
    write_reg(a2d_pkg::REG_UPSAMPLE, up);
  endtask

  // ready is checked mid-cycle, the transaction completes at the next rising edge
  task automatic push_byte(input logic [7:0] codes, input logic restart);
    in_tvalid <= 1'b1;
    in_tdata  <= codes;
    in_tuser  <= restart;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
  endtask

  task automatic input_gap();
    int pick;
    int gap;
    pick = $urandom_range(0, 99);
    if (pick < 55) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every expected sample is out, then let a dropped byte clear
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int                           target;
    int                           base;
    int                           since_restart;
    int                           per_track;
    int                           slack;
    logic [a2d_pkg::CfgDataW-1:0] len;
    logic [a2d_pkg::CfgDataW-1:0] up;
    logic                         restart;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // writes to unused indexes must not disturb the defaults
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, 24'h000005);
    push_byte(8'hFF, 1'b0);          // track used up since reset: dropped
    drain();
    write_reg(a2d_pkg::REG_TRACK_LENGTH, 24'd42);
    push_byte(8'hAA, 1'b1);          // walk step index down to its floor
    push_byte(8'hAA, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h55, 1'b0);          // climb to the top step, clip at +127
    push_byte(8'h55, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'hFF, 1'b0);          // fall and clip at -128
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hE4, 1'b0);
    push_byte(8'h1B, 1'b0);          // track ends mid-byte
    push_byte(8'h00, 1'b0);
    drain();
    write_reg(a2d_pkg::REG_TRACK_LENGTH, '0);
    push_byte(8'h55, 1'b1);          // restart on an empty track
    push_byte(8'h55, 1'b0);
    drain();
    configure(24'd1, 24'd0);         // repeat count of zero acts as one
    push_byte(8'hFE, 1'b1);
    drain();
    configure(24'd6, '1);            // repeat count saturates
    push_byte(8'h6C, 1'b1);
    push_byte(8'h93, 1'b0);
    drain();
    configure(TRACK_MAX, 24'hAAAAB0);
    push_byte(8'hC3, 1'b1);

    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: begin
          len = TRACK_MAX;
          up  = 24'd1;
        end
        1: begin
          len = a2d_pkg::CfgDataW'($urandom_range(1, 12));
          up  = 24'd2;
        end
        2: begin
          len = a2d_pkg::CfgDataW'($urandom_range(8, 40));
          up  = 24'd0;
        end
        3: begin
          len = a2d_pkg::CfgDataW'($urandom_range(1, 60));
          up  = a2d_pkg::CfgDataW'($urandom_range(17, 31));
        end
        4: begin
          len = a2d_pkg::CfgDataW'($urandom_range(1, 16));
          up  = 24'd16;
        end
        5: begin
          len = a2d_pkg::CfgDataW'($urandom_range(1, 3));
          up  = 24'd3;
        end
        6: begin
          len = a2d_pkg::CfgDataW'($urandom_range(1, 60));
          up  = a2d_pkg::CfgDataW'($urandom_range(1, 8));
        end
        default: begin
          len = a2d_pkg::CfgDataW'($urandom_range(61, 4000));
          up  = 24'd1;
        end
      endcase
      configure(len, up);
      steady_in     = ($urandom_range(0, 3) == 0);
      target        = (ph == 4) ? 20 : 55;
      base          = decoded_bytes;
      since_restart = 0;
      per_track     = (int'(len) + 3) / 4;
      slack         = $urandom_range(0, 2);
      while (decoded_bytes - base < target) begin
        if (since_restart == 0) restart = 1'b1;
        else if (since_restart >= per_track + slack) restart = 1'b1;
        else restart = ($urandom_range(0, 29) == 0);   // cut a track short
        push_byte(8'($urandom_range(0, 255)), restart);
        if (restart) begin
          since_restart = 1;
          slack = $urandom_range(0, 2);
        end else begin
          since_restart++;
        end
        if (!steady_in) input_gap();
        if ($urandom_range(0, 39) == 0) drain();
      end
    end

    drain();
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
